/* rtl/mel_pkg.sv */
// ----------------------------------------------------------------------------
// mel_pkg
// Shared types, token codes and the function-name table of the expression
// lexer.
// ----------------------------------------------------------------------------
package mel_pkg;

	localparam int CHAR_W       = 8;
	localparam int KIND_W       = 6;
	localparam int NUM_W        = 31;
	localparam int NAME_COUNT   = 22;
	localparam int NAME_MAX     = 6;   // longest function name
	localparam int MAX_TOKENS   = 8;   // tokens kept per item
	localparam int TK_NAME_BASE = 11;  // code of the first table entry

	localparam logic [CHAR_W-1:0] VAR_CHAR_RST = 8'h78;  // 'x'

	// token codes
	localparam logic [KIND_W-1:0] TK_END    = 6'd0;
	localparam logic [KIND_W-1:0] TK_PLUS   = 6'd1;
	localparam logic [KIND_W-1:0] TK_MINUS  = 6'd2;
	localparam logic [KIND_W-1:0] TK_TIMES  = 6'd3;
	localparam logic [KIND_W-1:0] TK_SLASH  = 6'd4;
	localparam logic [KIND_W-1:0] TK_POWER  = 6'd5;
	localparam logic [KIND_W-1:0] TK_LPAREN = 6'd6;
	localparam logic [KIND_W-1:0] TK_RPAREN = 6'd7;
	localparam logic [KIND_W-1:0] TK_NUMBER = 6'd8;
	localparam logic [KIND_W-1:0] TK_VAR    = 6'd9;
	localparam logic [KIND_W-1:0] TK_CONST  = 6'd10;

	// names, first character in the top byte, zero padded
	localparam logic [NAME_MAX*CHAR_W-1:0] NAME_TXT [NAME_COUNT] = '{
		{"abs", 24'h0}, "arcsin", "arccos", "arctan", "arccot", "arcsec", "arccsc",
		{"cosh", 16'h0}, {"cos", 24'h0}, {"coth", 16'h0}, {"cot", 24'h0},
		{"csch", 16'h0}, {"csc", 24'h0}, {"ln", 32'h0}, {"log", 24'h0},
		{"sech", 16'h0}, {"sec", 24'h0}, {"sinh", 16'h0}, {"sin", 24'h0},
		{"sqrt", 16'h0}, {"tanh", 16'h0}, {"tan", 24'h0}
	};

	localparam int NAME_LEN [NAME_COUNT] = '{
		3, 6, 6, 6, 6, 6, 6, 4, 3, 4, 3, 4, 3, 2, 3, 4, 3, 4, 3, 4, 4, 3
	};

	typedef enum logic [2:0] {
		CL_SPACE,
		CL_OP,
		CL_NAME,
		CL_DIGIT,
		CL_OTHER
	} mel_cls_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              end_of_text;
	} mel_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [CHAR_W-1:0] constant_char;
		logic [NUM_W-1:0]  number_value;
		logic              number_overflow;
		logic              last_of_run;
	} mel_result_t;

	// one classified character
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		mel_cls_t          cls;
		logic              is_var;
	} mel_char_t;

	// front-to-back queue entry
	typedef struct packed {
		mel_char_t c;
		logic      eot;
	} mel_entry_t;

endpackage

/* rtl/mel_fifo.sv */
// ----------------------------------------------------------------------------
// mel_fifo
// Small register FIFO with show-ahead read.
// ----------------------------------------------------------------------------
module mel_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_wr) - CNT_W'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/mel_front.sv */
// ----------------------------------------------------------------------------
// mel_front
// Input side: takes items, classifies the character and queues it for the
// scan engine.
// ----------------------------------------------------------------------------
module mel_front
	import mel_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mel_item_t         item,
	input  logic [CHAR_W-1:0] var_char,
	input  logic              q_pop,
	output logic              q_empty,
	output mel_entry_t        q_entry
);

	mel_entry_t ent;

	always_comb begin
		ent          = '0;
		ent.c.ch     = item.char_code;
		ent.c.is_var = (item.char_code == var_char);
		ent.eot      = item.end_of_text;
		case (item.char_code) inside
			" ", 8'h09, 8'h0A, 8'h0D:           ent.c.cls = CL_SPACE;  // tab, LF, CR
			"+", "-", "*", "/", "^", "(", ")": ent.c.cls = CL_OP;
			"a", "c", "l", "s", "t":           ent.c.cls = CL_NAME;   // can start a name
			["0":"9"]:                         ent.c.cls = CL_DIGIT;
			default:                           ent.c.cls = CL_OTHER;
		endcase
	end

	mel_fifo #(
		.WIDTH($bits(mel_entry_t)),
		.DEPTH(DEPTH)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (ent),
		.full  (full),
		.rd    (q_pop),
		.rdata (q_entry),
		.empty (q_empty)
	);

endmodule

/* rtl/mel_engine.sv */
// ----------------------------------------------------------------------------
// mel_engine
// Scan engine: one scan step per cycle unless the result queue stalls it,
// over a short buffer of pending name characters then characters to rescan.
// ----------------------------------------------------------------------------
module mel_engine
	import mel_pkg::*;
#(
	parameter int MAX_NAME_LEN = 6,
	parameter int NUMBER_BITS  = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  mel_entry_t  q_entry,
	output logic        q_pop,
	input  logic        res_full,
	output logic        res_push,
	output mel_result_t res_data
);

	localparam int BUF_D  = MAX_NAME_LEN + 1;
	localparam int IDX_W  = $clog2(BUF_D);
	localparam int CNT_W  = $clog2(BUF_D + 1);
	localparam int TCNT_W = $clog2(MAX_TOKENS + 1);
	localparam int ACC_X  = NUMBER_BITS + 4;
	localparam logic [NUMBER_BITS-1:0] NUM_MAX = '1;

	// state
	mel_char_t               sbuf_q [BUF_D];
	logic [CNT_W-1:0]        len_q;
	logic [CNT_W-1:0]        pend_q;
	logic                    in_num_q;
	logic                    sat_q;
	logic [NUMBER_BITS-1:0]  acc_q;
	logic                    act_q;
	logic                    eot_q;
	logic                    hold_vld_q;
	mel_result_t             hold_q;
	logic [TCNT_W-1:0]       tok_cnt_q;

	// step logic
	logic                    have_c;
	mel_char_t               cur;
	logic [CNT_W-1:0]        m_len;
	logic [NAME_MAX-1:0]     eq [NAME_COUNT];
	logic [NAME_COUNT-1:0]   pre_ok;
	logic [NAME_COUNT-1:0]   longer;
	logic [NAME_COUNT-1:0]   head;
	logic [NAME_MAX:0]       hit_len;
	logic [KIND_W-1:0]       code_len [NAME_MAX+1];
	logic                    best_hit;
	logic [CNT_W-1:0]        best_len;
	logic [KIND_W-1:0]       best_code;
	mel_result_t             rs_tok;
	logic [CNT_W-1:0]        rs_start;
	mel_result_t             num_tok;
	logic [ACC_X-1:0]        acc10;
	logic                    sat_hit;
	logic                    finish;
	logic                    load;
	logic                    tok_vld;
	mel_result_t             tok;
	logic                    keep;
	logic                    push_c;
	logic                    stall;
	logic [CNT_W-1:0]        drop;
	logic [CNT_W-1:0]        pend_n;
	logic [CNT_W-1:0]        len_n;
	logic                    in_num_n;
	logic                    sat_n;
	logic [NUMBER_BITS-1:0]  acc_n;
	logic                    eot_n;
	logic                    act_n;
	mel_char_t               sbuf_n [BUF_D];

	function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
		case (c)
			"+":     op_kind = TK_PLUS;
			"-":     op_kind = TK_MINUS;
			"*":     op_kind = TK_TIMES;
			"/":     op_kind = TK_SLASH;
			"^":     op_kind = TK_POWER;
			"(":     op_kind = TK_LPAREN;
			")":     op_kind = TK_RPAREN;
			default: op_kind = TK_END;
		endcase
	endfunction

	assign have_c = (pend_q < len_q);
	assign cur    = sbuf_q[pend_q[IDX_W-1:0]];
	// scanned length: pending chars plus the next one when there is one
	assign m_len  = (have_c && pend_q < CNT_W'(MAX_NAME_LEN)) ? pend_q + 1'b1 : pend_q;

	// name table compare against the buffer head
	always_comb begin
		logic pre_all;
		logic head_all;
		for (int i = 0; i < NAME_COUNT; i++) begin
			for (int k = 0; k < NAME_MAX; k++) begin
				eq[i][k] = (sbuf_q[k].ch ==
					NAME_TXT[i][CHAR_W*(NAME_MAX-1-k) +: CHAR_W]);
			end
		end
		for (int i = 0; i < NAME_COUNT; i++) begin
			pre_all  = 1'b1;
			head_all = 1'b1;
			for (int k = 0; k < NAME_MAX; k++) begin
				if (CNT_W'(k) < m_len && !eq[i][k]) pre_all = 1'b0;
				if (k < NAME_LEN[i] && !eq[i][k]) head_all = 1'b0;
			end
			pre_ok[i] = pre_all && (CNT_W'(NAME_LEN[i]) >= m_len);
			longer[i] = pre_all && (CNT_W'(NAME_LEN[i]) > m_len);
			head[i]   = head_all && (CNT_W'(NAME_LEN[i]) <= m_len);
		end
	end

	// longest complete name at the head; at most one hit per length
	always_comb begin
		hit_len = '0;
		for (int j = 0; j <= NAME_MAX; j++) code_len[j] = '0;
		for (int i = 0; i < NAME_COUNT; i++) begin
			if (head[i]) begin
				hit_len[NAME_LEN[i]]  = 1'b1;
				code_len[NAME_LEN[i]] = code_len[NAME_LEN[i]] | KIND_W'(TK_NAME_BASE + i);
			end
		end
		best_hit  = 1'b0;
		best_len  = '0;
		best_code = '0;
		for (int j = 1; j <= NAME_MAX; j++) begin
			if (hit_len[j]) begin
				best_hit  = 1'b1;
				best_len  = CNT_W'(j);
				best_code = code_len[j];
			end
		end
	end

	// failed name: longest head name, else first char as a single
	always_comb begin
		rs_tok = '0;
		if (best_hit) begin
			rs_tok.token_kind = best_code;
			rs_start          = best_len;
		end else begin
			if (sbuf_q[0].is_var) begin
				rs_tok.token_kind = TK_VAR;
			end else begin
				rs_tok.token_kind    = TK_CONST;
				rs_tok.constant_char = sbuf_q[0].ch;
			end
			rs_start = CNT_W'(1);
		end
	end

	always_comb begin
		num_tok                 = '0;
		num_tok.token_kind      = TK_NUMBER;
		num_tok.number_value    = NUM_W'(acc_q);
		num_tok.number_overflow = sat_q;
	end

	// acc*10 + digit, saturating
	assign acc10   = (ACC_X'(acc_q) << 3) + (ACC_X'(acc_q) << 1) + ACC_X'(cur.ch[3:0]);
	assign sat_hit = (acc10 > ACC_X'(NUM_MAX));

	assign finish  = act_q && !have_c && !eot_q;
	assign load    = (!act_q || finish) && !q_empty;

	always_comb begin
		tok_vld  = 1'b0;
		tok      = '0;
		drop     = '0;
		pend_n   = pend_q;
		in_num_n = in_num_q;
		acc_n    = acc_q;
		sat_n    = sat_q;
		eot_n    = eot_q;
		act_n    = act_q;
		if (act_q && !finish) begin
			if (have_c) begin
				if (in_num_q) begin
					if (cur.cls == CL_DIGIT) begin
						drop = CNT_W'(1);
						if (sat_hit) begin
							acc_n = NUM_MAX;
							sat_n = 1'b1;
						end else begin
							acc_n = acc10[NUMBER_BITS-1:0];
						end
					end else begin
						tok_vld  = 1'b1;
						tok      = num_tok;
						in_num_n = 1'b0;
						acc_n    = '0;
						sat_n    = 1'b0;
					end
				end else if (pend_q != '0) begin
					if (pend_q >= CNT_W'(MAX_NAME_LEN) || !(|pre_ok)) begin
						tok_vld = 1'b1;
						tok     = rs_tok;
						drop    = rs_start;
						pend_n  = '0;
					end else if (best_hit && best_len == m_len && !(|longer)) begin
						tok_vld        = 1'b1;
						tok.token_kind = best_code;
						drop           = m_len;
						pend_n         = '0;
					end else begin
						pend_n = m_len;
					end
				end else begin
					case (cur.cls)
						CL_SPACE: begin
							drop = CNT_W'(1);
						end
						CL_OP: begin
							tok_vld        = 1'b1;
							tok.token_kind = op_kind(cur.ch);
							drop           = CNT_W'(1);
						end
						CL_NAME: begin
							pend_n = CNT_W'(1);
						end
						CL_DIGIT: begin
							in_num_n = 1'b1;
							acc_n    = NUMBER_BITS'(cur.ch[3:0]);
							sat_n    = 1'b0;
							drop     = CNT_W'(1);
						end
						default: begin
							tok_vld = 1'b1;
							if (cur.is_var) begin
								tok.token_kind = TK_VAR;
							end else begin
								tok.token_kind    = TK_CONST;
								tok.constant_char = cur.ch;
							end
							drop = CNT_W'(1);
						end
					endcase
				end
			end else if (pend_q != '0) begin
				// end of text, flush pending name chars
				tok_vld = 1'b1;
				tok     = rs_tok;
				drop    = rs_start;
				pend_n  = '0;
			end else if (in_num_q) begin
				tok_vld  = 1'b1;
				tok      = num_tok;
				in_num_n = 1'b0;
				acc_n    = '0;
				sat_n    = 1'b0;
			end else begin
				tok_vld        = 1'b1;
				tok.token_kind = TK_END;
				eot_n          = 1'b0;
			end
		end
		if (finish) act_n = 1'b0;
		if (load) begin
			act_n = 1'b1;
			eot_n = q_entry.eot;
		end
	end

	// buffer: drop consumed chars from the head, append a loaded char
	always_comb begin
		for (int k = 0; k < BUF_D; k++) begin
			if (k + int'(drop) < BUF_D) begin
				sbuf_n[k] = sbuf_q[IDX_W'(k + int'(drop))];
			end else begin
				sbuf_n[k] = sbuf_q[k];
			end
		end
		len_n = len_q - drop;
		if (load && !q_entry.eot) begin
			sbuf_n[len_q[IDX_W-1:0]] = q_entry.c;
			len_n                    = len_q + 1'b1;
		end
	end

	// one token is held back until the next one or the end of the item
	assign keep     = tok_vld && (tok_cnt_q < TCNT_W'(MAX_TOKENS));
	assign push_c   = hold_vld_q && (keep || finish);
	assign stall    = push_c && res_full;
	assign res_push = push_c && !res_full;
	assign q_pop    = load && !stall;

	always_comb begin
		res_data             = hold_q;
		res_data.last_of_run = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BUF_D; k++) sbuf_q[k] <= '0;
			len_q      <= '0;
			pend_q     <= '0;
			in_num_q   <= 1'b0;
			sat_q      <= 1'b0;
			acc_q      <= '0;
			act_q      <= 1'b0;
			eot_q      <= 1'b0;
			hold_vld_q <= 1'b0;
			hold_q     <= '0;
			tok_cnt_q  <= '0;
		end else if (!stall) begin
			for (int k = 0; k < BUF_D; k++) sbuf_q[k] <= sbuf_n[k];
			len_q    <= len_n;
			pend_q   <= pend_n;
			in_num_q <= in_num_n;
			sat_q    <= sat_n;
			acc_q    <= acc_n;
			act_q    <= act_n;
			eot_q    <= eot_n;
			if (keep) begin
				hold_q     <= tok;
				hold_vld_q <= 1'b1;
				tok_cnt_q  <= tok_cnt_q + 1'b1;
			end else if (finish) begin
				hold_vld_q <= 1'b0;
				tok_cnt_q  <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_pend_in_buf: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= len_q)
		else $error("pending count beyond buffer fill");

	a_num_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_num_q |-> (pend_q == '0))
		else $error("digit run while name chars pending");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(MAX_NAME_LEN))
		else $error("scan buffer overfilled");

	a_hold_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> act_q)
		else $error("held token outside an item");

	a_finish_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !stall) |=> !hold_vld_q)
		else $error("held token left after item end");
`endif

endmodule

/* rtl/math_expression_lexer_unit.sv */
// ----------------------------------------------------------------------------
// math_expression_lexer_unit
// Streaming tokenizer for math expressions. Items carry one character, or
// an end-of-text mark; each item yields zero or more tokens, the last of
// them flagged with last_of_run. Whitespace is skipped, + - * / ^ ( ) give
// operator tokens, digit runs give one saturating number token, function
// names (abs, arc functions, trig and hyperbolic functions, ln, log, sqrt)
// match longest first, the character in variable_char gives a variable
// token and anything else a constant token. A number, or a name that a longer
// name could continue, is only given out once the following character closes
// it, so it comes out with a later item. End of text flushes what is pending,
// then gives the end token. The engine runs one step per cycle unless a full
// result queue stalls it; a step takes in one character, gives one token, or
// both. A plain character is first pulled into the scan buffer (overlapped
// with delivery of the previous item's last token), then scanned in a step.
// A number token is given before the character closing it is scanned; a
// failed name gives its fallback token, then rescans the rest. The item and
// result queues let the input side and the result side stall apart from the
// engine. The variable_char register is written through the cfg channel,
// always ready; the user must write it only while the block is idle, which
// the block itself does not enforce.
// ----------------------------------------------------------------------------
module math_expression_lexer_unit
	import mel_pkg::*;
#(
	parameter int MAX_NAME_LEN       = 6,   // scan buffer holds this plus one
	parameter int NUMBER_BITS        = 31,  // saturation point 2^NUMBER_BITS-1
	parameter int ITEM_QUEUE_DEPTH   = 2,
	parameter int RESULT_QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              push,
	output logic              full,
	input  mel_item_t         item,
	// result items
	output logic              empty,
	input  logic              pop,
	output mel_result_t       result,
	// variable_char register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CHAR_W-1:0] cfg_data
);

	logic [CHAR_W-1:0] var_char_q;
	logic              q_pop;
	logic              q_empty;
	mel_entry_t        q_entry;
	logic              res_push;
	logic              res_full;
	mel_result_t       res_data;

	// config register, written any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_char_q <= VAR_CHAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			var_char_q <= cfg_data;
		end
	end

	// front: accept and classify, queue for the engine
	mel_front #(
		.DEPTH(ITEM_QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.var_char(var_char_q),
		.q_pop   (q_pop),
		.q_empty (q_empty),
		.q_entry (q_entry)
	);

	// back: scan engine
	mel_engine #(
		.MAX_NAME_LEN(MAX_NAME_LEN),
		.NUMBER_BITS (NUMBER_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res_data(res_data)
	);

	// result queue, head is the oldest token
	mel_fifo #(
		.WIDTH($bits(mel_result_t)),
		.DEPTH(RESULT_QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res_data),
		.full  (res_full),
		.rd    (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule
